// File: hdl/lpfp_pkg.sv
// Shared constants for the length-prefixed frame parser.
`timescale 1ns / 1ps

package lpfp_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 32;
  localparam int unsigned HdrLenBytes = 4;
  localparam int unsigned HdrBytes   = 8;
  localparam int unsigned MinFrameLen = 8;

  localparam logic [WordW-1:0] HdrLenLast  = WordW'(HdrLenBytes - 1);
  localparam logic [WordW-1:0] HdrTypeFirst = WordW'(HdrLenBytes);
  localparam logic [WordW-1:0] HdrCount    = WordW'(HdrBytes);
  localparam logic [WordW-1:0] HdrLast     = WordW'(HdrBytes - 1);
  localparam logic [WordW-1:0] MinLen      = WordW'(MinFrameLen);

endpackage

// File: hdl/length_prefixed_frame_parser.sv
// Top level of the length-prefixed frame parser: byte tagging and header decode.
// An accepted input's result item is in the output register from the next cycle on.
// Throughput: one item per cycle while out_ready is high; the only loop is the 32-bit byte counter and its compare.
// The input is ready whenever the output register is empty or is being taken.
// Reset (rst, synchronous) empties the output register and returns the parser to
// expecting a new header.
`timescale 1ns / 1ps

module length_prefixed_frame_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpfp_pkg::ByteW-1:0]    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lpfp_pkg::ByteW-1:0]    out_byte,
  output logic                          in_header,
  output logic                          frame_first,
  output logic                          frame_last,
  output logic [lpfp_pkg::WordW-1:0]    msg_type,
  output logic                          short_frame
);

  // Frame state.
  logic [lpfp_pkg::WordW-1:0] bytes_seen;
  logic [lpfp_pkg::WordW-1:0] frame_len;
  logic [lpfp_pkg::WordW-1:0] type_shift;
  logic                       len_was_short;

  logic [lpfp_pkg::WordW-1:0] frame_len_next;
  logic [lpfp_pkg::WordW-1:0] type_shift_next;
  logic                       len_was_short_next;
  logic [lpfp_pkg::WordW:0]   pos_plus1;
  logic                       hdr;
  logic                       first;
  logic                       last;
  logic                       accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Header decode: assemble the length and the message type, big-endian, and raise a length below the minimum to it.
  always_comb begin
    frame_len_next     = frame_len;
    type_shift_next    = type_shift;
    len_was_short_next = len_was_short;
    first = (bytes_seen == '0);
    hdr   = (bytes_seen < lpfp_pkg::HdrCount);
    if (bytes_seen < lpfp_pkg::HdrTypeFirst) begin
      if (first) begin
        frame_len_next     = {{(lpfp_pkg::WordW-lpfp_pkg::ByteW){1'b0}}, in_byte};
        len_was_short_next = 1'b0;
        type_shift_next    = '0;
      end else begin
        frame_len_next = {frame_len[lpfp_pkg::WordW-lpfp_pkg::ByteW-1:0], in_byte};
      end
      if (bytes_seen == lpfp_pkg::HdrLenLast && frame_len_next < lpfp_pkg::MinLen) begin
        frame_len_next     = lpfp_pkg::MinLen;
        len_was_short_next = 1'b1;
      end
    end else if (hdr) begin
      if (bytes_seen == lpfp_pkg::HdrTypeFirst) begin
        type_shift_next = {{(lpfp_pkg::WordW-lpfp_pkg::ByteW){1'b0}}, in_byte};
      end else begin
        type_shift_next = {type_shift[lpfp_pkg::WordW-lpfp_pkg::ByteW-1:0], in_byte};
      end
    end
  end

  // End of frame: the counter compare is one bit wider so it never wraps.
  assign pos_plus1 = {1'b0, bytes_seen} + {{lpfp_pkg::WordW{1'b0}}, 1'b1};
  assign last = (bytes_seen >= lpfp_pkg::HdrLast) &&
                (pos_plus1 >= {1'b0, frame_len_next});

  // State update on each accepted item; the last byte returns to the reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      frame_len     <= '0;
      type_shift    <= '0;
      len_was_short <= 1'b0;
    end else if (accept) begin
      if (last) begin
        bytes_seen    <= '0;
        frame_len     <= '0;
        type_shift    <= '0;
        len_was_short <= 1'b0;
      end else begin
        bytes_seen    <= pos_plus1[lpfp_pkg::WordW-1:0];
        frame_len     <= frame_len_next;
        type_shift    <= type_shift_next;
        len_was_short <= len_was_short_next;
      end
    end
  end

  // Output register: valid flag is control state, payload loads with each item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte    <= in_byte;
      in_header   <= hdr;
      frame_first <= first;
      frame_last  <= last;
      msg_type    <= last ? type_shift_next : '0;
      short_frame <= last && len_was_short_next;
    end
  end

  // Checks on the parser's own logic.
  a_tail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_last) |-> (msg_type == '0 && !short_frame))
    else $error("msg_type or short_frame set on a byte that does not end a frame");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (bytes_seen == '0))
    else $error("parser did not return to header state after the last byte");

  a_first_hdr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_first) |-> in_header)
    else $error("first byte of a frame not tagged as header");

  a_len_min: assert property (@(posedge clk) disable iff (rst)
    (bytes_seen >= lpfp_pkg::HdrTypeFirst) |-> (frame_len >= lpfp_pkg::MinLen))
    else $error("declared length below minimum after the length field");

  a_short_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && short_frame) |-> (frame_last && in_header))
    else $error("short frame did not end on its header");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the length-prefixed frame parser.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned HalfPeriod = 10;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseBytes = 500;
  localparam int unsigned DirectedBytes = 25;
  localparam int unsigned SettleCycles = 5;

  // One tagged byte as the parser presents it on its output.
  typedef struct packed {
    logic [lpfp_pkg::ByteW-1:0] data;
    logic                       hdr;
    logic                       first;
    logic                       last;
    logic [lpfp_pkg::WordW-1:0] mtype;
    logic                       short_flag;
  } frame_tag_t;

  // Tracks the frame position of every accepted byte and checks the tags that come back.
  class frame_tag_checker;
    logic [lpfp_pkg::WordW-1:0] bytes_taken;
    logic [lpfp_pkg::WordW-1:0] declared_len;
    logic [lpfp_pkg::WordW-1:0] type_acc;
    logic                       len_raised;
    frame_tag_t                 expected_tags[$];
    int unsigned                errors;

    function new();
      clear_frame();
      errors = 0;
    endfunction

    function void clear_frame();
      bytes_taken  = '0;
      declared_len = '0;
      type_acc     = '0;
      len_raised   = 1'b0;
    endfunction

    // Works out the tags for one accepted byte and advances the frame state.
    function void note_byte(input logic [lpfp_pkg::ByteW-1:0] b);
      frame_tag_t                 tag;
      logic [lpfp_pkg::WordW-1:0] pos;
      logic                       ends;
      pos = bytes_taken;
      if (pos < lpfp_pkg::HdrTypeFirst) begin
        if (pos == '0) begin
          declared_len = {{(lpfp_pkg::WordW-lpfp_pkg::ByteW){1'b0}}, b};
          len_raised   = 1'b0;
          type_acc     = '0;
        end else begin
          declared_len = {declared_len[lpfp_pkg::WordW-lpfp_pkg::ByteW-1:0], b};
        end
        // A declared length shorter than the header is raised to the header size.
        if (pos == lpfp_pkg::HdrLenLast && declared_len < lpfp_pkg::MinLen) begin
          declared_len = lpfp_pkg::MinLen;
          len_raised   = 1'b1;
        end
      end else if (pos < lpfp_pkg::HdrCount) begin
        if (pos == lpfp_pkg::HdrTypeFirst) begin
          type_acc = {{(lpfp_pkg::WordW-lpfp_pkg::ByteW){1'b0}}, b};
        end else begin
          type_acc = {type_acc[lpfp_pkg::WordW-lpfp_pkg::ByteW-1:0], b};
        end
      end
      // The end compare is one bit wider so a maximal length never wraps.
      ends = (pos >= lpfp_pkg::HdrLast) &&
             (({1'b0, pos} + 33'd1) >= {1'b0, declared_len});
      tag.data       = b;
      tag.hdr        = (pos < lpfp_pkg::HdrCount);
      tag.first      = (pos == '0);
      tag.last       = ends;
      tag.mtype      = ends ? type_acc : '0;
      tag.short_flag = ends ? len_raised : 1'b0;
      expected_tags.push_back(tag);
      if (ends) begin
        clear_frame();
      end else begin
        bytes_taken = pos + 1;
      end
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compares one output item with the oldest pending expectation.
    task check_tags(input frame_tag_t got);
      frame_tag_t want;
      if (expected_tags.size() == 0) begin
        report($sformatf("output item %h with no byte pending", got.data));
        return;
      end
      want = expected_tags.pop_front();
      if (got.data !== want.data)
        report($sformatf("out_byte %h, want %h", got.data, want.data));
      if (got.hdr !== want.hdr)
        report($sformatf("in_header %b, want %b (byte %h)", got.hdr, want.hdr, want.data));
      if (got.first !== want.first)
        report($sformatf("frame_first %b, want %b (byte %h)", got.first, want.first, want.data));
      if (got.last !== want.last)
        report($sformatf("frame_last %b, want %b (byte %h)", got.last, want.last, want.data));
      if (got.mtype !== want.mtype)
        report($sformatf("msg_type %h, want %h", got.mtype, want.mtype));
      if (got.short_flag !== want.short_flag)
        report($sformatf("short_frame %b, want %b", got.short_flag, want.short_flag));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [lpfp_pkg::ByteW-1:0] in_byte = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [lpfp_pkg::ByteW-1:0] out_byte;
  logic                       in_header;
  logic                       frame_first;
  logic                       frame_last;
  logic [lpfp_pkg::WordW-1:0] msg_type;
  logic                       short_frame;

  frame_tag_checker tags;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      bytes_sent = 0;
  int unsigned      cycle_count = 0;

  length_prefixed_frame_parser dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .in_header   (in_header),
    .frame_first (frame_first),
    .frame_last  (frame_last),
    .msg_type    (msg_type),
    .short_frame (short_frame)
  );

  always #(HalfPeriod) clk = ~clk;

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every output item taken is checked against the prediction.
  always @(posedge clk) begin : watch_results
    frame_tag_t got;
    if (!rst && out_valid && out_ready) begin
      got.data       = out_byte;
      got.hdr        = in_header;
      got.first      = frame_first;
      got.last       = frame_last;
      got.mtype      = msg_type;
      got.short_flag = short_frame;
      tags.check_tags(got);
    end
  end

  // Hard stop in case the handshake hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("length_prefixed_frame_parser regression: fail");
      $finish;
    end
  end

  // Offers one byte, with random idle cycles first, and waits for it to be taken.
  task automatic send_byte(input logic [lpfp_pkg::ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    tags.note_byte(b);
    bytes_sent++;
  endtask

  // Sends a header with the given fields, then random payload up to n_bytes in all.
  task automatic send_frame(input logic [lpfp_pkg::WordW-1:0] len_field,
                            input logic [lpfp_pkg::WordW-1:0] type_field,
                            input int unsigned n_bytes);
    logic [lpfp_pkg::WordW-1:0] rnd;
    for (int i = 0; i < lpfp_pkg::HdrLenBytes; i++)
      send_byte(len_field[lpfp_pkg::WordW-1-lpfp_pkg::ByteW*i -: lpfp_pkg::ByteW]);
    for (int i = 0; i < lpfp_pkg::HdrLenBytes; i++)
      send_byte(type_field[lpfp_pkg::WordW-1-lpfp_pkg::ByteW*i -: lpfp_pkg::ByteW]);
    for (int i = lpfp_pkg::HdrBytes; i < n_bytes; i++) begin
      rnd = $urandom;
      send_byte(rnd[lpfp_pkg::ByteW-1:0]);
    end
  endtask

  // Mostly well-formed frames of modest length, some short ones, a few past 255 bytes.
  task automatic random_frame();
    logic [lpfp_pkg::WordW-1:0] len_field;
    logic [lpfp_pkg::WordW-1:0] rnd;
    int unsigned                total;
    rnd = $urandom;
    if ($urandom_range(49) == 0) begin
      len_field = {16'h0000, 8'h01, rnd[lpfp_pkg::ByteW-1:0]};
    end else if ($urandom_range(5) == 0) begin
      len_field = $urandom_range(0, lpfp_pkg::MinFrameLen - 1);
    end else begin
      len_field = $urandom_range(lpfp_pkg::MinFrameLen, 40);
    end
    total = (len_field < lpfp_pkg::MinLen) ? lpfp_pkg::HdrBytes : len_field;
    send_frame(len_field, $urandom, total);
  endtask

  // Holds the sender off until every expected item has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (tags.expected_tags.size() != 0) @(posedge clk);
  endtask

  initial begin
    tags = new();
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Zero length with an all-ones type, a header-only frame, and one payload byte.
    send_frame(32'h0000_0000, 32'hFFFF_FFFF, lpfp_pkg::HdrBytes);
    send_frame(32'h0000_0008, 32'h0000_0000, lpfp_pkg::HdrBytes);
    send_frame(32'h0000_0009, 32'h8001_7FFE, lpfp_pkg::HdrBytes + 1);

    // Three idle patterns, with a full drain between them.
    for (int phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0: begin
          send_idle_pct  = 37;
          recv_stall_pct = 47;
        end
        1: begin
          send_idle_pct  = 47;
          recv_stall_pct = 37;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (bytes_sent < DirectedBytes + (phase + 1) * PhaseBytes) random_frame();
      drain();
    end

    // A maximal declared length: the frame is still open when the stream stops.
    send_frame(32'hFFFF_FFFF, $urandom, 48);
    in_valid <= 1'b0;

    while (tags.expected_tags.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (tags.errors == 0) begin
      $display("length_prefixed_frame_parser regression: pass");
    end else begin
      $display("length_prefixed_frame_parser regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/lpfp_pkg.sv
hdl/length_prefixed_frame_parser.sv
tb/sv/tb_top.sv
